>>> rtl/assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMPL(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`endif

>>> rtl/bsc_pkg.sv
// Types and constants of the barometric compensation core.
`timescale 1ns / 1ps
package bsc_pkg;

  localparam int unsigned CFG_INDEX_W = 2;
  localparam int unsigned CFG_DATA_W  = 64;
  localparam int unsigned DIV_BITS    = 64;

  localparam logic [CFG_INDEX_W-1:0] REG_TEMP_COEFFS = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_PRESS_LOW   = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_PRESS_HIGH  = 2'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_PRESS_NINE  = 2'd3;

  localparam logic signed [32:0] FINE_OFFSET = 33'sd128000;
  localparam logic signed [34:0] CENT_ROUND  = 35'sd128;
  localparam logic [20:0]        PRESS_BASE  = 21'd1048576;
  localparam logic [63:0]        BIAS_47     = 64'h0000_8000_0000_0000;
  localparam logic [11:0]        DIV_SCALE   = 12'd3125;

  typedef struct packed {
    logic [7:0] press_msb;
    logic [7:0] press_lsb;
    logic [7:0] press_xlsb;
    logic [7:0] temp_msb;
    logic [7:0] temp_lsb;
    logic [7:0] temp_xlsb;
  } sample_t;

  typedef struct packed {
    logic signed [31:0] fine_temperature;
    logic signed [31:0] temperature_centi_c;
    logic [31:0]        pressure_q24_8;
    logic               divide_fault;
  } result_t;

  // Temperature results that ride along with the pressure math.
  typedef struct packed {
    logic signed [31:0] fine;
    logic signed [31:0] cent;
  } meta_t;

  typedef struct packed {
    meta_t meta;
    logic  neg;
    logic  fault;
  } div_side_t;

endpackage

>>> rtl/bsc_stream_if.sv
// Valid/ready stream channel carrying one item per handshake.
`timescale 1ns / 1ps
interface bsc_stream_if #(parameter type T = logic) ();
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

>>> rtl/bsc_div.sv
// Pipelined restoring divider, one quotient bit per stage, unsigned magnitudes.
`timescale 1ns / 1ps
module bsc_div
  import bsc_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             adv,
  input  logic             in_valid,
  input  logic [63:0]      num,
  input  logic [30:0]      den,
  input  div_side_t        in_side,
  output logic             out_valid,
  output logic [63:0]      quo,
  output div_side_t        out_side
);

  logic            v    [DIV_BITS];
  logic [63:0]     nq   [DIV_BITS];
  logic [30:0]     rem  [DIV_BITS];
  logic [30:0]     dq   [DIV_BITS];
  div_side_t       side [DIV_BITS];

  for (genvar k = 0; k < DIV_BITS; k++) begin : g_stage
    logic            pv;
    logic [63:0]     pnq;
    logic [30:0]     prem;
    logic [30:0]     pd;
    div_side_t       pside;
    logic [31:0]     trial;
    logic            ge;

    if (k == 0) begin : g_first
      assign pv    = in_valid;
      assign pnq   = num;
      assign prem  = '0;
      assign pd    = den;
      assign pside = in_side;
    end else begin : g_rest
      assign pv    = v[k-1];
      assign pnq   = nq[k-1];
      assign prem  = rem[k-1];
      assign pd    = dq[k-1];
      assign pside = side[k-1];
    end

    assign trial = {prem, pnq[63]};
    assign ge    = (trial >= {1'b0, pd});

    always_ff @(posedge clk) begin
      if (rst) begin
        v[k] <= 1'b0;
      end else if (adv) begin
        v[k] <= pv;
      end
    end

    // The remainder stays below the divisor, so 31 bits hold it.
    always_ff @(posedge clk) begin
      if (adv) begin
        nq[k]   <= {pnq[62:0], ge};
        rem[k]  <= ge ? 31'(trial - {1'b0, pd}) : trial[30:0];
        dq[k]   <= pd;
        side[k] <= pside;
      end
    end
  end

  assign out_valid = v[DIV_BITS-1];
  assign quo       = nq[DIV_BITS-1];
  assign out_side  = side[DIV_BITS-1];

endmodule

>>> rtl/barometric_sensor_compensation_core.sv
// Top level of the barometric sensor compensation pipeline.
`timescale 1ns / 1ps
// Compensates one raw barometer measurement per item: six result bytes in,
// fine temperature, temperature in hundredths of a degree Celsius, pressure
// in pascals as unsigned Q24.8 and a divide fault flag out. The core is a
// fully pipelined datapath of 80 register stages: one item is accepted every
// cycle while the output is not stalled. Most of the pipeline depth comes
// from the 64-bit signed division, which takes one quotient bit per stage
// over 64 stages; eleven stages before it evaluate the temperature and the
// divisor and numerator, five after it finish the
// pressure. A stall at the output freezes every stage at once, so no item is
// lost or repeated. Calibration registers are written through the plain
// write port and must only change while no item is in flight; after reset
// they are all zero, which makes the divisor zero: pressure then reads 0 and
// divide_fault is set, while the temperature outputs stay valid.
module barometric_sensor_compensation_core
  import bsc_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  bsc_stream_if.sink             sample,
  bsc_stream_if.source           result
);

  // Calibration registers.
  logic [47:0] temp_coeffs;
  logic [63:0] press_coeffs_low;
  logic [63:0] press_coeffs_high;
  logic [15:0] press_coeff_nine;

  always_ff @(posedge clk) begin
    if (rst) begin
      temp_coeffs       <= '0;
      press_coeffs_low  <= '0;
      press_coeffs_high <= '0;
      press_coeff_nine  <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_TEMP_COEFFS: temp_coeffs       <= cfg_data[47:0];
        REG_PRESS_LOW:   press_coeffs_low  <= cfg_data;
        REG_PRESS_HIGH:  press_coeffs_high <= cfg_data;
        REG_PRESS_NINE:  press_coeff_nine  <= cfg_data[15:0];
        default:         press_coeff_nine  <= press_coeff_nine;
      endcase
    end
  end

  // Unpacked coefficients. The user must keep them static while items are in
  // flight, which the block does not enforce, so every stage reads them directly.
  logic [15:0]        t1, p1;
  logic signed [15:0] t2, t3, p2, p3, p4, p5, p6, p7, p8, p9;

  assign t1 = temp_coeffs[15:0];
  assign t2 = temp_coeffs[31:16];
  assign t3 = temp_coeffs[47:32];
  assign p1 = press_coeffs_low[15:0];
  assign p2 = press_coeffs_low[31:16];
  assign p3 = press_coeffs_low[47:32];
  assign p4 = press_coeffs_low[63:48];
  assign p5 = press_coeffs_high[15:0];
  assign p6 = press_coeffs_high[31:16];
  assign p7 = press_coeffs_high[47:32];
  assign p8 = press_coeffs_high[63:48];
  assign p9 = press_coeff_nine;

  // The whole pipeline moves together unless the output holds a result
  // that has not been taken.
  logic adv;
  logic [10:0] front_v;
  logic [4:0]  back_v;

  // Divider outputs.
  logic        div_valid;
  logic [63:0] div_quo;
  div_side_t   div_side;

  assign adv          = !back_v[4] || result.ready;
  assign sample.ready = adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      front_v <= '0;
      back_v  <= '0;
    end else if (adv) begin
      front_v <= {front_v[9:0], sample.valid};
      back_v  <= {back_v[3:0], div_valid};
    end
  end

  // Stage 0: unpack the raw 20-bit readings.
  logic [19:0] s0_adct, s0_adcp;

  always_ff @(posedge clk) begin
    if (adv) begin
      s0_adct <= {sample.data.temp_msb, sample.data.temp_lsb, sample.data.temp_xlsb[7:4]};
      s0_adcp <= {sample.data.press_msb, sample.data.press_lsb, sample.data.press_xlsb[7:4]};
    end
  end

  // Stage 1: first temperature products.
  logic signed [17:0] t_diff;
  logic signed [16:0] t_d;
  logic signed [33:0] s1_ta, s1_dd;
  logic [19:0]        s1_adcp;

  assign t_diff = $signed({1'b0, s0_adct[19:3]}) - $signed({1'b0, t1, 1'b0});
  assign t_d    = $signed({1'b0, s0_adct[19:4]}) - $signed({1'b0, t1});

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_ta   <= t_diff * t2;
      s1_dd   <= t_d * t_d;
      s1_adcp <= s0_adcp;
    end
  end

  // Stage 2: scale and apply T3 to the squared term.
  logic signed [22:0] s2_ta;
  logic signed [37:0] s2_tb;
  logic signed [21:0] dd_sh;
  logic [19:0]        s2_adcp;

  assign dd_sh = s1_dd[33:12];

  always_ff @(posedge clk) begin
    if (adv) begin
      s2_ta   <= s1_ta[33:11];
      s2_tb   <= dd_sh * t3;
      s2_adcp <= s1_adcp;
    end
  end

  // Stage 3: fine temperature.
  logic signed [31:0] s3_fine;
  logic [19:0]        s3_adcp;

  always_ff @(posedge clk) begin
    if (adv) begin
      s3_fine <= {{9{s2_ta[22]}}, s2_ta} + {{8{s2_tb[37]}}, s2_tb[37:14]};
      s3_adcp <= s2_adcp;
    end
  end

  // Stage 4: hundredths of a degree and the pressure offset term.
  logic signed [34:0] cent_full;
  logic signed [32:0] s4_pa;
  meta_t              s4_meta;
  logic [19:0]        s4_adcp;

  assign cent_full = {{3{s3_fine[31]}}, s3_fine} + {s3_fine[31], s3_fine, 2'b00} + CENT_ROUND;

  always_ff @(posedge clk) begin
    if (adv) begin
      s4_pa        <= {s3_fine[31], s3_fine} - FINE_OFFSET;
      s4_meta.fine <= s3_fine;
      s4_meta.cent <= {{5{cent_full[34]}}, cent_full[34:8]};
      s4_adcp      <= s3_adcp;
    end
  end

  // Stage 5: square of the offset and its products with P5 and P2.
  logic signed [65:0] aa_full;
  logic signed [63:0] s5_aa;
  logic signed [48:0] s5_ap5, s5_ap2;
  meta_t              s5_meta;
  logic [19:0]        s5_adcp;

  assign aa_full = s4_pa * s4_pa;

  always_ff @(posedge clk) begin
    if (adv) begin
      s5_aa   <= aa_full[63:0];
      s5_ap5  <= s4_pa * p5;
      s5_ap2  <= s4_pa * p2;
      s5_meta <= s4_meta;
      s5_adcp <= s4_adcp;
    end
  end

  // Stage 6: square times P6 and P3, wrapping to 64 bits.
  logic signed [79:0] aap6_full, aap3_full;
  logic signed [63:0] s6_aap6, s6_aap3;
  logic signed [48:0] s6_ap5, s6_ap2;
  meta_t              s6_meta;
  logic [19:0]        s6_adcp;

  assign aap6_full = s5_aa * p6;
  assign aap3_full = s5_aa * p3;

  always_ff @(posedge clk) begin
    if (adv) begin
      s6_aap6 <= aap6_full[63:0];
      s6_aap3 <= aap3_full[63:0];
      s6_ap5  <= s5_ap5;
      s6_ap2  <= s5_ap2;
      s6_meta <= s5_meta;
      s6_adcp <= s5_adcp;
    end
  end

  // Stage 7: the numerator offset and the divisor polynomial.
  logic signed [63:0] ap5_64, ap2_64, p4_64, aap3_sh;
  logic [63:0]        s7_b, s7_a2;
  meta_t              s7_meta;
  logic [19:0]        s7_adcp;

  assign ap5_64  = {{15{s6_ap5[48]}}, s6_ap5};
  assign ap2_64  = {{15{s6_ap2[48]}}, s6_ap2};
  assign p4_64   = {{48{p4[15]}}, p4};
  assign aap3_sh = s6_aap3 >>> 8;

  always_ff @(posedge clk) begin
    if (adv) begin
      s7_b    <= s6_aap6 + (ap5_64 <<< 17) + (p4_64 <<< 35);
      s7_a2   <= aap3_sh + (ap2_64 <<< 12);
      s7_meta <= s6_meta;
      s7_adcp <= s6_adcp;
    end
  end

  // Stage 8: scale by P1 and form the numerator before the 3125 factor.
  logic [63:0] a2_bias;
  logic [79:0] x_full;
  logic [20:0] p_diff;
  logic [63:0] s8_x, s8_nsub;
  meta_t       s8_meta;

  assign a2_bias = s7_a2 + BIAS_47;
  assign x_full  = a2_bias * p1;
  assign p_diff  = PRESS_BASE - {1'b0, s7_adcp};

  always_ff @(posedge clk) begin
    if (adv) begin
      s8_x    <= x_full[63:0];
      s8_nsub <= {12'd0, p_diff, 31'd0} - s7_b;
      s8_meta <= s7_meta;
    end
  end

  // Stage 9: divisor and full numerator.
  logic [75:0] n_full;
  logic [30:0] s9_dv;
  logic [63:0] s9_n;
  meta_t       s9_meta;

  assign n_full = s8_nsub * DIV_SCALE;

  always_ff @(posedge clk) begin
    if (adv) begin
      s9_dv   <= s8_x[63:33];
      s9_n    <= n_full[63:0];
      s9_meta <= s8_meta;
    end
  end

  // Stage 10: magnitudes and quotient sign for the divider. The most
  // negative numerator keeps its magnitude as 2^63, which wraps correctly.
  logic [63:0] s10_nmag;
  logic [30:0] s10_dmag;
  div_side_t   s10_side;

  always_ff @(posedge clk) begin
    if (adv) begin
      s10_nmag       <= s9_n[63] ? 64'd0 - s9_n : s9_n;
      s10_dmag       <= s9_dv[30] ? 31'd0 - s9_dv : s9_dv;
      s10_side.meta  <= s9_meta;
      s10_side.neg   <= s9_n[63] ^ s9_dv[30];
      s10_side.fault <= (s9_dv == '0);
    end
  end

  bsc_div u_div (
    .clk       (clk),
    .rst       (rst),
    .adv       (adv),
    .in_valid  (front_v[10]),
    .num       (s10_nmag),
    .den       (s10_dmag),
    .in_side   (s10_side),
    .out_valid (div_valid),
    .quo       (div_quo),
    .out_side  (div_side)
  );

  // Stage 11: signed quotient.
  logic signed [63:0] s11_p;
  meta_t              s11_meta;
  logic               s11_fault;

  always_ff @(posedge clk) begin
    if (adv) begin
      s11_p     <= div_side.neg ? 64'd0 - div_quo : div_quo;
      s11_meta  <= div_side.meta;
      s11_fault <= div_side.fault;
    end
  end

  // Stage 12: P9 times the scaled quotient, and P8 times the quotient.
  logic signed [50:0] x13;
  logic signed [66:0] u_full;
  logic signed [79:0] pb_full;
  logic [63:0]        s12_u;
  logic [50:0]        s12_x13;
  logic signed [63:0] s12_p, s12_pb;
  meta_t              s12_meta;
  logic               s12_fault;

  assign x13     = s11_p[63:13];
  assign u_full  = p9 * x13;
  assign pb_full = p8 * s11_p;

  always_ff @(posedge clk) begin
    if (adv) begin
      s12_u     <= u_full[63:0];
      s12_x13   <= x13;
      s12_pb    <= pb_full[63:0];
      s12_p     <= s11_p;
      s12_meta  <= s11_meta;
      s12_fault <= s11_fault;
    end
  end

  // Stage 13: partial products of the 64-bit wrapping multiply.
  logic [63:0]        x64;
  logic [63:0]        hl_full, lh_full;
  logic [63:0]        s13_ll;
  logic [31:0]        s13_hl, s13_lh;
  logic signed [63:0] s13_p, s13_pb;
  meta_t              s13_meta;
  logic               s13_fault;

  assign x64     = {{13{s12_x13[50]}}, s12_x13};
  assign hl_full = s12_u[63:32] * x64[31:0];
  assign lh_full = s12_u[31:0] * x64[63:32];

  always_ff @(posedge clk) begin
    if (adv) begin
      s13_ll    <= s12_u[31:0] * x64[31:0];
      s13_hl    <= hl_full[31:0];
      s13_lh    <= lh_full[31:0];
      s13_p     <= s12_p;
      s13_pb    <= s12_pb;
      s13_meta  <= s12_meta;
      s13_fault <= s12_fault;
    end
  end

  // Stage 14: combine the partial products.
  logic signed [63:0] s14_m, s14_p, s14_pb;
  meta_t              s14_meta;
  logic               s14_fault;

  always_ff @(posedge clk) begin
    if (adv) begin
      s14_m     <= s13_ll + {s13_hl + s13_lh, 32'd0};
      s14_p     <= s13_p;
      s14_pb    <= s13_pb;
      s14_meta  <= s13_meta;
      s14_fault <= s13_fault;
    end
  end

  // Stage 15: final pressure sum; this is the output register.
  logic signed [63:0] m_sh, pb_sh, sum1, sum1_sh, p7_64, press;
  result_t            res;

  assign m_sh    = s14_m >>> 25;
  assign pb_sh   = s14_pb >>> 19;
  assign sum1    = s14_p + m_sh + pb_sh;
  assign sum1_sh = sum1 >>> 8;
  assign p7_64   = {{48{p7[15]}}, p7};
  assign press   = sum1_sh + (p7_64 <<< 4);

  always_ff @(posedge clk) begin
    if (adv) begin
      res.fine_temperature    <= s14_meta.fine;
      res.temperature_centi_c <= s14_meta.cent;
      res.pressure_q24_8      <= s14_fault ? 32'd0 : press[31:0];
      res.divide_fault        <= s14_fault;
    end
  end

  assign result.valid = back_v[4];
  assign result.data  = res;

endmodule

>>> rtl/bsc_checker.sv
// Port-level checker for the compensation core, bound to the top level.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module bsc_checker
  import bsc_pkg::*;
(
  input logic    clk,
  input logic    rst,
  input logic    smp_ready,
  input logic    res_valid,
  input logic    res_ready,
  input result_t res_data
);

  // A fault result never carries a pressure value.
  `ASSERT_IMPL(a_fault_zero, clk, rst, res_valid && res_data.divide_fault, res_data.pressure_q24_8 == 32'd0)

  // With the output register empty the core always takes an item.
  `ASSERT_IMPL(a_ready_when_empty, clk, rst, !res_valid, smp_ready)

  // Reset empties the pipeline.
  `ASSERT_NEXT(a_reset_empty, clk, 1'b0, rst, !res_valid)

  // A stalled result holds.
  `ASSERT_NEXT(a_stall_hold, clk, rst, res_valid && !res_ready, res_valid && $stable(res_data))

endmodule

bind barometric_sensor_compensation_core bsc_checker u_bsc_checker (
  .clk       (clk),
  .rst       (rst),
  .smp_ready (sample.ready),
  .res_valid (result.valid),
  .res_ready (result.ready),
  .res_data  (result.data)
);

>>> tb/sv/tb.sv
// Self-checking testbench of the barometric sensor compensation core.
`timescale 1ns / 1ps
module tb;
  import bsc_pkg::*;

  localparam int unsigned RUN_LIMIT = 400000;
  localparam int unsigned PIPE_DEPTH = 80;

  logic clk;
  logic rst;
  logic cfg_we;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  bsc_stream_if #(.T(sample_t)) sample_ch ();
  bsc_stream_if #(.T(result_t)) result_ch ();

  barometric_sensor_compensation_core u_dut (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .sample(sample_ch),
    .result(result_ch)
  );

  // Shadow copy of the calibration registers, kept at their stored widths.
  logic [47:0] cal_temp;
  logic [63:0] cal_press_low;
  logic [63:0] cal_press_high;
  logic [15:0] cal_p9;

  // Expected results in acceptance order.
  result_t compensated_q[$];

  bit idle_on;
  int unsigned stall_left;
  int unsigned cycle_count;
  int unsigned items_sent;
  int unsigned results_checked;
  int unsigned faults_seen;
  int unsigned mismatch_count;
  int unsigned orphan_count;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Predicts one result with the 64-bit wrapping integer form of the
  // compensation formulas. All shifts of signed values are arithmetic.
  function automatic result_t compensate(sample_t s);
    result_t r;
    longint adc_p, adc_t, t1, p1;
    shortint t2, t3, p2, p3, p4, p5, p6, p7, p8, p9;
    longint a, b, d, fine, cent, p, num;
    adc_p = longint'({44'd0, s.press_msb, s.press_lsb, s.press_xlsb[7:4]});
    adc_t = longint'({44'd0, s.temp_msb, s.temp_lsb, s.temp_xlsb[7:4]});
    t1 = longint'({48'd0, cal_temp[15:0]});
    t2 = cal_temp[31:16];
    t3 = cal_temp[47:32];
    p1 = longint'({48'd0, cal_press_low[15:0]});
    p2 = cal_press_low[31:16];
    p3 = cal_press_low[47:32];
    p4 = cal_press_low[63:48];
    p5 = cal_press_high[15:0];
    p6 = cal_press_high[31:16];
    p7 = cal_press_high[47:32];
    p8 = cal_press_high[63:48];
    p9 = cal_p9;

    // Temperature never overflows 64 bits.
    a = (((adc_t >>> 3) - (t1 <<< 1)) * longint'(t2)) >>> 11;
    d = (adc_t >>> 4) - t1;
    b = (((d * d) >>> 12) * longint'(t3)) >>> 14;
    fine = a + b;
    cent = (fine * 5 + 128) >>> 8;

    // Pressure intermediates wrap modulo 2^64.
    a = fine - 64'sd128000;
    b = a * a * longint'(p6);
    b = b + ((a * longint'(p5)) <<< 17);
    b = b + (longint'(p4) <<< 35);
    a = ((a * a * longint'(p3)) >>> 8) + ((a * longint'(p2)) <<< 12);
    a = ((64'sh0000_8000_0000_0000 + a) * p1) >>> 33;

    r.fine_temperature = fine[31:0];
    r.temperature_centi_c = cent[31:0];
    if (a == 0) begin
      r.pressure_q24_8 = '0;
      r.divide_fault = 1'b1;
    end else begin
      p = 64'sd1048576 - adc_p;
      num = ((p <<< 31) - b) * 64'sd3125;
      // The most negative numerator over minus one wraps to itself.
      if (a == -1) p = -num;
      else p = num / a;
      a = (longint'(p9) * (p >>> 13) * (p >>> 13)) >>> 25;
      b = (longint'(p8) * p) >>> 19;
      p = ((p + a + b) >>> 8) + (longint'(p7) <<< 4);
      r.pressure_q24_8 = p[31:0];
      r.divide_fault = 1'b0;
    end
    return r;
  endfunction

  // Loads all four calibration registers on consecutive cycles.
  task automatic load_calibration(logic [63:0] temp_word, logic [63:0] low_word,
                                  logic [63:0] high_word, logic [63:0] nine_word);
    logic [63:0] words [4];
    logic [CFG_INDEX_W-1:0] idx [4];
    words = '{temp_word, low_word, high_word, nine_word};
    idx = '{REG_TEMP_COEFFS, REG_PRESS_LOW, REG_PRESS_HIGH, REG_PRESS_NINE};
    for (int i = 0; i < 4; i++) begin
      @(posedge clk);
      cfg_we <= 1'b1;
      cfg_index <= idx[i];
      cfg_data <= words[i];
    end
    @(posedge clk);
    cfg_we <= 1'b0;
    // Bits above each register's width are dropped by the block.
    cal_temp = temp_word[47:0];
    cal_press_low = low_word;
    cal_press_high = high_word;
    cal_p9 = nine_word[15:0];
  endtask

  // Offers one item and returns once the block has taken it. Valid is left
  // high so back-to-back items never toggle it within one time step.
  task automatic send_sample(sample_t s);
    if (idle_on && $urandom_range(0, 5) == 0) begin
      sample_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
    end
    sample_ch.valid <= 1'b1;
    sample_ch.data <= s;
    do @(posedge clk); while (!sample_ch.ready);
    compensated_q.push_back(compensate(s));
    items_sent++;
  endtask

  // Lowers valid after the last item and lets the pipeline empty.
  task automatic drain;
    sample_ch.valid <= 1'b0;
    while (compensated_q.size() != 0) @(posedge clk);
    repeat (PIPE_DEPTH + 10) @(posedge clk);
  endtask

  function automatic sample_t random_sample();
    sample_t s;
    s = sample_t'({$urandom(), 16'($urandom())});
    return s;
  endfunction

  // Realistic raw readings sit near the middle of the 20-bit range.
  function automatic sample_t plausible_sample();
    sample_t s;
    s = random_sample();
    s.press_msb = 8'($urandom_range(8'h40, 8'h70));
    s.temp_msb = 8'($urandom_range(8'h70, 8'h90));
    return s;
  endfunction

  // Typical calibration: T1..T3 and P1..P9 as found in a real part.
  task automatic load_typical;
    load_calibration({16'hDEAD, 16'(-16'sd1000), 16'sd26435, 16'd27504},
                     {16'sd2855, 16'sd3024, 16'(-16'sd10685), 16'd36477},
                     {16'(-16'sd14600), 16'sd15500, 16'(-16'sd7), 16'sd140},
                     {48'hFFFF_0000_1234, 16'sd6000});
  endtask

  task automatic test_reset_defaults;
    sample_t s;
    // All coefficients are zero after reset, so every divisor is zero.
    s = '0;
    send_sample(s);
    s = '1;
    send_sample(s);
    for (int i = 0; i < 4; i++) send_sample(random_sample());
    drain();
  endtask

  task automatic test_field_extremes;
    sample_t s;
    load_typical();
    s = '0;
    send_sample(s);
    s = '1;
    send_sample(s);
    s = sample_t'({6{8'hAA}});
    send_sample(s);
    s = sample_t'({6{8'h55}});
    send_sample(s);
    // Only the low nibbles of the extra bytes set: they must be ignored.
    s = '0;
    s.press_xlsb = 8'h0F;
    s.temp_xlsb = 8'h0F;
    send_sample(s);
    s = '0;
    s.press_xlsb = 8'hF0;
    s.temp_xlsb = 8'hF0;
    send_sample(s);
    for (int i = 0; i < 4; i++) send_sample(plausible_sample());
    drain();
  endtask

  task automatic test_extreme_coefficients;
    sample_t s;
    // Largest positive and most negative coefficients push the pressure
    // chain into wraparound.
    load_calibration(64'hFFFF_7FFF_7FFF_FFFF, 64'h7FFF_7FFF_7FFF_FFFF,
                     64'h7FFF_7FFF_7FFF_7FFF, 64'h0000_0000_0000_7FFF);
    s = '0;
    send_sample(s);
    s = '1;
    send_sample(s);
    send_sample(plausible_sample());
    drain();
    load_calibration(64'h0000_8000_8000_FFFF, 64'h8000_8000_8000_0001,
                     64'h8000_8000_8000_8000, 64'hFFFF_FFFF_FFFF_8000);
    s = '0;
    send_sample(s);
    s = '1;
    send_sample(s);
    send_sample(plausible_sample());
    drain();
    // Zero P1 with nonzero others still gives the divide fault.
    load_calibration(64'h0001_0001_0001_0001, 64'h0001_0001_0001_0000,
                     64'h0001_0001_0001_0001, 64'h0000_0000_0000_0001);
    send_sample(plausible_sample());
    drain();
  endtask

  // One random phase: random or typical calibration, then mostly plausible
  // readings with a share of arbitrary bytes.
  task automatic test_random_phase(int unsigned n, bit typical);
    if (typical) load_typical();
    else load_calibration({$urandom(), $urandom()}, {$urandom(), $urandom()},
                          {$urandom(), $urandom()}, {$urandom(), $urandom()});
    for (int unsigned i = 0; i < n; i++) begin
      if ($urandom_range(0, 3) == 0) send_sample(random_sample());
      else send_sample(plausible_sample());
    end
    drain();
  endtask

  // Output stall: random bursts while idling is enabled, else always ready.
  always @(posedge clk) begin
    if (rst) begin
      result_ch.ready <= 1'b0;
      stall_left <= 0;
    end else if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      result_ch.ready <= 1'b0;
    end else if (idle_on && $urandom_range(0, 7) == 0) begin
      stall_left <= $urandom_range(0, 6);
      result_ch.ready <= 1'b0;
    end else begin
      result_ch.ready <= 1'b1;
    end
  end

  // Compares each accepted result with the oldest expectation.
  always @(posedge clk) begin
    result_t want;
    result_t got;
    if (!rst && result_ch.valid && result_ch.ready) begin
      got = result_ch.data;
      if (compensated_q.size() == 0) begin
        orphan_count++;
        if (orphan_count <= 10) $display("unexpected result %h", got);
      end else begin
        want = compensated_q.pop_front();
        results_checked++;
        if (want.divide_fault) faults_seen++;
        if (got.fine_temperature !== want.fine_temperature ||
            got.temperature_centi_c !== want.temperature_centi_c ||
            got.pressure_q24_8 !== want.pressure_q24_8 ||
            got.divide_fault !== want.divide_fault) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("mismatch at result %0d: fine %h/%h cent %h/%h press %h/%h fault %b/%b",
                     results_checked, want.fine_temperature, got.fine_temperature,
                     want.temperature_centi_c, got.temperature_centi_c,
                     want.pressure_q24_8, got.pressure_q24_8,
                     want.divide_fault, got.divide_fault);
        end
      end
    end
  end

  // Watchdog against a hung pipeline.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > RUN_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("CHECK FAILED");
      $finish;
    end
  end

  initial begin
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    sample_ch.valid = 1'b0;
    sample_ch.data = '0;
    cycle_count = 0;
    items_sent = 0;
    results_checked = 0;
    faults_seen = 0;
    mismatch_count = 0;
    orphan_count = 0;
    idle_on = 1'b1;
    cal_temp = '0;
    cal_press_low = '0;
    cal_press_high = '0;
    cal_p9 = '0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_reset_defaults();
    test_field_extremes();
    test_extreme_coefficients();
    test_random_phase(400, 1'b1);
    for (int i = 0; i < 4; i++) test_random_phase(250, 1'b0);
    test_random_phase(100, 1'b0);
    load_calibration(64'h0, 64'h0, 64'h0, 64'h0);
    for (int i = 0; i < 50; i++) send_sample(random_sample());
    drain();
    // Last stretch runs at full rate on both sides.
    idle_on = 1'b0;
    test_random_phase(400, 1'b1);

    $display("sent %0d items over several calibration sets, %0d results checked,",
             items_sent, results_checked);
    $display("%0d with divide fault, %0d mismatches", faults_seen, mismatch_count);
    if (mismatch_count == 0 && orphan_count == 0 && compensated_q.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end
endmodule

>>> sim.f
+incdir+rtl
rtl/bsc_pkg.sv
rtl/bsc_stream_if.sv
rtl/bsc_div.sv
rtl/barometric_sensor_compensation_core.sv
rtl/bsc_checker.sv
tb/sv/tb.sv
